### hdl/hscp_pkg.sv
package hscp_pkg;

  // plane selector codes
  localparam logic [2:0] KIND_XMIN = 3'd0;
  localparam logic [2:0] KIND_XMAX = 3'd1;
  localparam logic [2:0] KIND_YMIN = 3'd2;
  localparam logic [2:0] KIND_YMAX = 3'd3;
  localparam logic [2:0] KIND_ZMIN = 3'd4;
  localparam logic [2:0] KIND_ZMAX = 3'd5;

  localparam int KindWidth       = 3;
  localparam int DefCoordWidth   = 32;
  localparam int DefFracBits     = 16;
  localparam int QueueDepth      = 2;
  localparam int OutQueueDepth   = 2;

endpackage

### hdl/homogeneous_segment_plane_clip_unit.sv
// The back pipeline holds the divider, which resolves one quotient bit per
// stage, ahead of the multiply and combine stages.
// Throughput: one word per cycle, sustained while the result side keeps up.
// Reset: synchronous, active-low rst_n empties both queues and all stage
// valid bits; datapath registers are not reset.
module homogeneous_segment_plane_clip_unit #(
  parameter int COORD_WIDTH = hscp_pkg::DefCoordWidth,
  parameter int FRAC_BITS   = hscp_pkg::DefFracBits
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic [hscp_pkg::KindWidth-1:0] in_kind,
  input  logic signed [COORD_WIDTH-1:0]  in_ax,
  input  logic signed [COORD_WIDTH-1:0]  in_ay,
  input  logic signed [COORD_WIDTH-1:0]  in_az,
  input  logic signed [COORD_WIDTH-1:0]  in_aw,
  input  logic signed [COORD_WIDTH-1:0]  in_bx,
  input  logic signed [COORD_WIDTH-1:0]  in_by,
  input  logic signed [COORD_WIDTH-1:0]  in_bz,
  input  logic signed [COORD_WIDTH-1:0]  in_bw,
  output logic                           empty,
  input  logic                           pop,
  output logic signed [COORD_WIDTH-1:0]  out_cx,
  output logic signed [COORD_WIDTH-1:0]  out_cy,
  output logic signed [COORD_WIDTH-1:0]  out_cz,
  output logic signed [COORD_WIDTH-1:0]  out_cw,
  output logic signed [COORD_WIDTH-1:0]  out_param_t
);
  import hscp_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int FW = KindWidth + 4*W + 4*(W+1) + 2*W + 5;

  logic [3:0][W-1:0] av, bv;
  logic              q_full, q_push, q_empty, q_pop;
  logic [FW-1:0]     q_win, q_wout;
  logic              o_full, o_push, o_empty;
  logic [5*W-1:0]    o_win, o_wout;

  assign av = {in_aw, in_az, in_ay, in_ax};
  assign bv = {in_bw, in_bz, in_by, in_bx};

  // front: accept and classify
  hscp_front #(.W(W)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (push),
    .in_full (full),
    .kind    (in_kind),
    .av      (av),
    .bv      (bv),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_word  (q_win)
  );

  // decoupling queue between front and back
  hscp_fifo #(.WIDTH(FW), .DEPTH(QueueDepth)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_win),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_wout),
    .empty (q_empty)
  );

  // back: divide, multiply, combine
  hscp_back #(.W(W), .F(FRAC_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_word  (q_wout),
    .q_pop   (q_pop),
    .o_full  (o_full),
    .o_push  (o_push),
    .o_word  (o_win)
  );

  // result queue
  hscp_fifo #(.WIDTH(5*W), .DEPTH(OutQueueDepth)) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (o_push),
    .din   (o_win),
    .full  (o_full),
    .pop   (pop),
    .dout  (o_wout),
    .empty (o_empty)
  );

  assign empty = o_empty;
  assign {out_param_t, out_cw, out_cz, out_cy, out_cx} = o_wout;

endmodule

### hdl/hscp_fifo.sv
module hscp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];

  // pointer and count update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    if (do_push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

### hdl/hscp_front.sv
module hscp_front #(
  parameter int W = hscp_pkg::DefCoordWidth
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [hscp_pkg::KindWidth-1:0] kind,
  input  logic [3:0][W-1:0]              av,
  input  logic [3:0][W-1:0]              bv,
  input  logic                           q_full,
  output logic                           q_push,
  output logic [hscp_pkg::KindWidth+4*W+4*(W+1)+2*W+5-1:0] q_word
);
  import hscp_pkg::*;

  localparam int FW = KindWidth + 4*W + 4*(W+1) + 2*W + 5;

  logic          fr_valid_r;
  logic [FW-1:0] fr_word_r, fr_word_nxt;
  logic          take;

  assign take    = in_push && !in_full;
  assign q_push  = fr_valid_r && !q_full;
  assign in_full = fr_valid_r && q_full;
  assign q_word  = fr_word_r;

  // deltas, plane numerator and denominator
  always_comb begin
    logic [3:0][W:0]     dv;
    logic [1:0]          axis;
    logic                is_max;
    logic signed [W+1:0] ai, aw, num;
    logic signed [W+2:0] di, dw, den;
    for (int i = 0; i < 4; i++) begin
      dv[i] = $signed({bv[i][W-1], bv[i]}) - $signed({av[i][W-1], av[i]});
    end
    axis   = kind[2:1];
    is_max = kind[0];
    ai     = $signed({{2{av[axis][W-1]}}, av[axis]});
    aw     = $signed({{2{av[3][W-1]}}, av[3]});
    di     = $signed({{2{dv[axis][W]}}, dv[axis]});
    dw     = $signed({{2{dv[3][W]}}, dv[3]});
    if (is_max) begin
      num = ai - aw;
      den = dw - di;
    end else begin
      num = -ai - aw;
      den = di + dw;
    end
    fr_word_nxt = {kind, av, dv, num, den};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (take) begin
      fr_valid_r <= 1'b1;
    end else if (q_push) begin
      fr_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fr_word_r <= fr_word_nxt;
    end
  end

endmodule

### hdl/hscp_back.sv
module hscp_back #(
  parameter int W = hscp_pkg::DefCoordWidth,
  parameter int F = hscp_pkg::DefFracBits
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  logic [hscp_pkg::KindWidth+4*W+4*(W+1)+2*W+5-1:0] q_word,
  output logic                  q_pop,
  input  logic                  o_full,
  output logic                  o_push,
  output logic [5*W-1:0]        o_word
);
  import hscp_pkg::*;

  localparam int NST = W + 7;
  localparam int OW  = 2*W + F + 3;

  typedef struct packed {
    logic [3:0][W-1:0] a;
    logic [3:0][W:0]   dm;
    logic [3:0]        dn;
    logic [1:0]        axis;
    logic              is_max;
    logic              bad;
    logic [W-1:0]      t;
  } sb_t;

  typedef struct packed {
    logic [W+1:0] r;
    logic [W-1:0] nlo;
    logic [W-1:0] q;
    logic [W+1:0] dm;
    logic         neg;
    logic         zero;
    logic         ovf;
    sb_t          sb;
  } dst_t;

  // one restoring division step: one quotient bit
  function automatic dst_t div_step(input dst_t s);
    dst_t        o;
    logic [W+2:0] r2;
    logic         ge;
    o  = s;
    r2 = {s.r, s.nlo[W-1]};
    ge = (r2 >= {1'b0, s.dm});
    o.r   = ge ? (W+2)'(r2 - {1'b0, s.dm}) : r2[W+1:0];
    o.nlo = {s.nlo[W-2:0], 1'b0};
    o.q   = {s.q[W-2:0], ge};
    return o;
  endfunction

  logic [NST-1:0] v_r, v_nxt;
  logic           en;

  sb_t            sb0_r;
  logic [W:0]     nm0_r;
  logic [W+1:0]   dm0_r;
  logic           neg0_r, zero0_r;
  sb_t            sb0_nxt;
  logic [W:0]     nm0_nxt;
  logic [W+1:0]   dm0_nxt;
  logic           neg0_nxt, zero0_nxt;

  dst_t           dst_r [W+1];
  dst_t           dst0_nxt;

  sb_t            sbt_r, sbt_nxt;
  logic [W-1:0]   tmag_r, tmag_nxt;
  logic           tneg_r, tneg_nxt;

  sb_t                  sbm1_r, sbm2_r, sbm3_r;
  logic [3:0][2*W:0]    prod_r;
  logic [3:0]           pneg_r;
  logic [3:0][W-1:0]    s_r, s_nxt;
  logic [3:0][W-1:0]    c_r, c_nxt;
  logic [5*W-1:0]       o_word_r, o_word_nxt;

  // global stall: only the last stage waits on the result queue
  assign en     = !v_r[NST-1] || !o_full;
  assign o_push = v_r[NST-1] && !o_full;
  assign q_pop  = en && !q_empty;
  assign o_word = o_word_r;
  assign v_nxt  = en ? {v_r[NST-2:0], !q_empty} : v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // stage 0: unpack, magnitudes and signs
  always_comb begin
    logic [KindWidth-1:0] kind;
    logic [3:0][W-1:0]    a;
    logic [3:0][W:0]      d;
    logic [W+1:0]         num;
    logic [W+2:0]         den;
    {kind, a, d, num, den} = q_word;
    sb0_nxt.a = a;
    for (int i = 0; i < 4; i++) begin
      sb0_nxt.dm[i] = d[i][W] ? (W+1)'(-d[i]) : d[i];
      sb0_nxt.dn[i] = d[i][W];
    end
    sb0_nxt.axis   = kind[2:1];
    sb0_nxt.is_max = kind[0];
    sb0_nxt.bad    = (kind > KIND_ZMAX);
    sb0_nxt.t      = '0;
    nm0_nxt   = num[W+1] ? (W+1)'(-num) : num[W:0];
    dm0_nxt   = den[W+2] ? (W+2)'(-den) : den[W+1:0];
    neg0_nxt  = num[W+1] ^ den[W+2];
    zero0_nxt = (den == '0) || sb0_nxt.bad;
  end

  // stage 1: quotient overflow check and initial remainder
  always_comb begin
    logic [W+F:0] nwide, nsh;
    nwide = {nm0_r, {F{1'b0}}};
    nsh   = nwide >> W;
    dst0_nxt.r    = nsh[W+1:0];
    dst0_nxt.nlo  = nwide[W-1:0];
    dst0_nxt.q    = '0;
    dst0_nxt.dm   = dm0_r;
    dst0_nxt.neg  = neg0_r;
    dst0_nxt.zero = zero0_r;
    dst0_nxt.ovf  = (OW'(nwide) >= OW'({dm0_r, {W{1'b0}}}));
    dst0_nxt.sb   = sb0_r;
  end

  // t: saturate quotient, apply sign
  always_comb begin
    logic [W-1:0] lim, mag;
    dst_t         s;
    s    = dst_r[W];
    lim  = s.neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    mag  = (s.ovf || (s.q > lim)) ? lim : s.q;
    tmag_nxt = s.zero ? '0 : mag;
    tneg_nxt = s.neg && !s.zero;
    sbt_nxt   = s.sb;
    sbt_nxt.t = tneg_nxt ? -tmag_nxt : tmag_nxt;
  end

  // scaled products, saturated and signed
  always_comb begin
    logic [2*W:0] sh;
    logic [W-1:0] lim, m;
    for (int i = 0; i < 4; i++) begin
      sh  = prod_r[i] >> F;
      lim = pneg_r[i] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      m   = (sh > (2*W+1)'(lim)) ? lim : sh[W-1:0];
      s_nxt[i] = pneg_r[i] ? -m : m;
    end
  end

  // a + t*d, saturated
  always_comb begin
    logic [W:0] sum;
    for (int i = 0; i < 4; i++) begin
      sum = {sbm2_r.a[i][W-1], sbm2_r.a[i]} + {s_r[i][W-1], s_r[i]};
      if (sum[W] != sum[W-1]) begin
        c_nxt[i] = sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        c_nxt[i] = sum[W-1:0];
      end
    end
  end

  // force the clipped coordinate onto the plane
  always_comb begin
    logic [3:0][W-1:0] c;
    logic [W-1:0]      negw;
    c    = c_r;
    negw = (c_r[3] == {1'b1, {(W-1){1'b0}}}) ? {1'b0, {(W-1){1'b1}}} : -c_r[3];
    for (int i = 0; i < 4; i++) begin
      if (!sbm3_r.bad && (sbm3_r.axis == 2'(i))) begin
        c[i] = sbm3_r.is_max ? c_r[3] : negw;
      end
    end
    o_word_nxt = {sbm3_r.t, c};
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (en) begin
      sb0_r    <= sb0_nxt;
      nm0_r    <= nm0_nxt;
      dm0_r    <= dm0_nxt;
      neg0_r   <= neg0_nxt;
      zero0_r  <= zero0_nxt;
      dst_r[0] <= dst0_nxt;
      for (int j = 0; j < W; j++) begin
        dst_r[j+1] <= div_step(dst_r[j]);
      end
      sbt_r  <= sbt_nxt;
      tmag_r <= tmag_nxt;
      tneg_r <= tneg_nxt;
      for (int i = 0; i < 4; i++) begin
        prod_r[i] <= (2*W+1)'(tmag_r) * (2*W+1)'(sbt_r.dm[i]);
        pneg_r[i] <= tneg_r ^ sbt_r.dn[i];
      end
      sbm1_r   <= sbt_r;
      s_r      <= s_nxt;
      sbm2_r   <= sbm1_r;
      c_r      <= c_nxt;
      sbm3_r   <= sbm2_r;
      o_word_r <= o_word_nxt;
    end
  end

endmodule
